FILE: rtl/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared widths, register indexes, config record and hash constants for the
// content-defined chunker.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int BYTE_W        = 8;
  localparam int OFFSET_W      = 40;
  localparam int LEN_W         = 21;
  localparam int HASH_W        = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 40;

  localparam int WINDOW_BYTES  = 48;
  localparam int MIN_CUT_SIZE  = 64;
  localparam int MASK_BITS     = 16;
  localparam int SLOT_W        = $clog2(WINDOW_BYTES);

  localparam logic [HASH_W-1:0] HASH_BASE = HASH_W'(31);
  localparam logic [LEN_W-1:0]  MAX_LIMIT = LEN_W'(1048576);

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK_SIZE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CONTENT_DEFINED = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_LENGTH     = CFG_INDEX_W'(2);

  localparam logic [LEN_W-1:0] RESET_MAX_CHUNK_SIZE = LEN_W'(4096);

  typedef struct packed {
    logic [LEN_W-1:0]    max_chunk_size;
    logic                content_defined;
    logic [OFFSET_W-1:0] data_length;
  } cfg_t;

  function automatic logic [HASH_W-1:0] window_power_f();
    logic [HASH_W-1:0] p;
    p = HASH_W'(1);
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      p = p * HASH_BASE;
    end
    return p;
  endfunction

  localparam logic [HASH_W-1:0] WINDOW_POWER = window_power_f();

endpackage

FILE: rtl/cdc_byte_if.sv
// ----------------------------------------------------------------------------
// cdc_byte_if
// Valid/ready channel carrying one stream byte per transfer.
// ----------------------------------------------------------------------------
interface cdc_byte_if;
  logic                       valid;
  logic                       ready;
  logic [cdc_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/cdc_chunk_if.sv
// ----------------------------------------------------------------------------
// cdc_chunk_if
// Valid/ready channel carrying one chunk descriptor per transfer.
// ----------------------------------------------------------------------------
interface cdc_chunk_if;
  logic                         valid;
  logic                         ready;
  logic [cdc_pkg::OFFSET_W-1:0] chunk_base;
  logic [cdc_pkg::LEN_W-1:0]    chunk_length;
  logic                         final_chunk;

  modport source (output valid, output chunk_base, output chunk_length,
                  output final_chunk, input ready);
  modport sink   (input valid, input chunk_base, input chunk_length,
                  input final_chunk, output ready);
endinterface

FILE: rtl/cdc_ram.sv
// ----------------------------------------------------------------------------
// cdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cdc_cfg_regs
// Configuration register file: maximum chunk size, mode and stream length.
// ----------------------------------------------------------------------------
module cdc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cdc_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_chunk_size  <= cdc_pkg::RESET_MAX_CHUNK_SIZE;
      cfg.content_defined <= 1'b0;
      cfg.data_length     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdc_pkg::REG_MAX_CHUNK_SIZE: begin
          cfg.max_chunk_size <= cfg_wdata[cdc_pkg::LEN_W-1:0];
        end
        cdc_pkg::REG_CONTENT_DEFINED: begin
          cfg.content_defined <= cfg_wdata[0];
        end
        cdc_pkg::REG_DATA_LENGTH: begin
          cfg.data_length <= cfg_wdata[cdc_pkg::OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/cdc_byte_queue.sv
// ----------------------------------------------------------------------------
// cdc_byte_queue
// Front end: takes stream bytes into a two-entry queue ahead of the engine.
// ----------------------------------------------------------------------------
module cdc_byte_queue (
  input  logic       clk,
  input  logic       rst,
  cdc_byte_if.sink   bytes,
  cdc_byte_if.source head
);

  logic [cdc_pkg::BYTE_W-1:0] slots [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 count;
  logic                       push;
  logic                       pop;

  assign bytes.ready    = (count != 2'd2);
  assign head.valid     = (count != 2'd0);
  assign head.data_byte = slots[rd_ptr];
  assign push           = bytes.valid && bytes.ready;
  assign pop            = head.valid && head.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= bytes.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/cdc_back.sv
// ----------------------------------------------------------------------------
// cdc_back
// Chunk engine: rolling hash over the window, cut decision and descriptor
// output register.
// ----------------------------------------------------------------------------
module cdc_back (
  input  logic          clk,
  input  logic          rst,
  input  cdc_pkg::cfg_t cfg,
  cdc_byte_if.sink      head,
  cdc_chunk_if.source   chunks
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_HASH
  } state_t;

  state_t                        state;
  logic [cdc_pkg::LEN_W-1:0]     bytes_in_chunk;
  logic [cdc_pkg::LEN_W-1:0]     chunk_limit;
  logic [cdc_pkg::OFFSET_W-1:0]  chunk_start;
  logic                          cutting_enabled;
  logic [cdc_pkg::HASH_W-1:0]    rolling_value;
  logic [cdc_pkg::HASH_W-1:0]    drop;
  logic [cdc_pkg::SLOT_W-1:0]    slot;
  logic                          out_valid;

  logic [cdc_pkg::BYTE_W-1:0]    win_rdata;
  logic                          win_we;

  logic                          chunk_head;
  logic                          stream_done;
  logic [cdc_pkg::OFFSET_W-1:0]  remaining;
  logic [cdc_pkg::LEN_W-1:0]     max_clamped;
  logic [cdc_pkg::LEN_W-1:0]     lim;
  logic                          window_full;
  logic [cdc_pkg::HASH_W-1:0]    drop_product;
  logic [cdc_pkg::HASH_W-1:0]    diff;
  logic [cdc_pkg::HASH_W-1:0]    rolling_next;
  logic [cdc_pkg::LEN_W-1:0]     len;
  logic                          done;
  logic                          out_blocked;
  logic                          commit;
  logic                          emit;
  logic [cdc_pkg::OFFSET_W:0]    end_sum;
  logic [cdc_pkg::SLOT_W-1:0]    slot_next;

  cdc_ram #(
    .WIDTH (cdc_pkg::BYTE_W),
    .DEPTH (cdc_pkg::WINDOW_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (slot),
    .wdata (head.data_byte),
    .raddr (slot),
    .rdata (win_rdata)
  );

  // chunk start limit
  always_comb begin
    chunk_head  = (bytes_in_chunk == '0);
    stream_done = (chunk_start >= cfg.data_length);
    remaining   = cfg.data_length - chunk_start;
    if (cfg.max_chunk_size == '0) begin
      max_clamped = cdc_pkg::LEN_W'(1);
    end else if (cfg.max_chunk_size > cdc_pkg::MAX_LIMIT) begin
      max_clamped = cdc_pkg::MAX_LIMIT;
    end else begin
      max_clamped = cfg.max_chunk_size;
    end
    if (remaining < {{(cdc_pkg::OFFSET_W-cdc_pkg::LEN_W){1'b0}}, max_clamped}) begin
      lim = remaining[cdc_pkg::LEN_W-1:0];
    end else begin
      lim = max_clamped;
    end
  end

  // hash update and cut decision
  always_comb begin
    window_full  = (bytes_in_chunk >= cdc_pkg::LEN_W'(cdc_pkg::WINDOW_BYTES));
    drop_product = {{(cdc_pkg::HASH_W-cdc_pkg::BYTE_W){1'b0}}, win_rdata} *
                   cdc_pkg::WINDOW_POWER;
    diff         = rolling_value - drop;
    rolling_next = (diff << 5) - diff +
                   {{(cdc_pkg::HASH_W-cdc_pkg::BYTE_W){1'b0}}, head.data_byte};
    len          = bytes_in_chunk + cdc_pkg::LEN_W'(1);
    done         = (len >= chunk_limit) ||
                   (cutting_enabled && window_full &&
                    (rolling_next[cdc_pkg::MASK_BITS-1:0] == '0));
    out_blocked  = out_valid && !chunks.ready;
    commit       = (state == S_HASH) && !(done && out_blocked);
    emit         = commit && done;
    end_sum      = {1'b0, chunk_start} +
                   {{(cdc_pkg::OFFSET_W-cdc_pkg::LEN_W+1){1'b0}}, len};
    slot_next    = (slot == cdc_pkg::SLOT_W'(cdc_pkg::WINDOW_BYTES - 1)) ?
                   '0 : slot + cdc_pkg::SLOT_W'(1);
    win_we       = commit;
    head.ready   = commit ||
                   ((state == S_IDLE) && head.valid && chunk_head && stream_done);
  end

  assign chunks.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      bytes_in_chunk  <= '0;
      chunk_limit     <= '0;
      chunk_start     <= '0;
      cutting_enabled <= 1'b0;
      rolling_value   <= '0;
      drop            <= '0;
      slot            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (chunks.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid && !(chunk_head && stream_done)) begin
            if (chunk_head) begin
              chunk_limit     <= lim;
              cutting_enabled <= cfg.content_defined &&
                                 (lim > cdc_pkg::LEN_W'(cdc_pkg::MIN_CUT_SIZE));
              rolling_value   <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          drop  <= window_full ? drop_product : '0;
          state <= S_HASH;
        end
        S_HASH: begin
          if (commit) begin
            state <= S_IDLE;
            if (done) begin
              chunks.chunk_base   <= chunk_start;
              chunks.chunk_length <= len;
              chunks.final_chunk  <= (end_sum >= {1'b0, cfg.data_length});
              chunk_start         <= end_sum[cdc_pkg::OFFSET_W-1:0];
              bytes_in_chunk      <= '0;
              rolling_value       <= '0;
              slot                <= '0;
            end else begin
              bytes_in_chunk <= len;
              rolling_value  <= rolling_next;
              slot           <= slot_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/content_defined_chunker_top.sv
// ----------------------------------------------------------------------------
// content_defined_chunker_top
// Cuts a byte stream of configured length into chunks and emits one
// descriptor (offset, length, final flag) per chunk.
// ----------------------------------------------------------------------------
// Bytes enter a two-entry queue and are taken by the chunk engine, which
// hashes each byte in steps: it reads the 48-byte window RAM, then does the
// 8x32 drop-term multiply, then the hash update and cut decision. The engine
// takes no new byte until it is through with the last one; a byte that
// arrives after the stream is complete is dropped with no descriptor. Limit
// and mode are latched at each chunk start, so register writes take effect
// from the next chunk. Descriptors sit in an output register, and the engine
// stalls only when a cut is due while that register still holds an untaken
// descriptor.
module content_defined_chunker_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  cdc_byte_if.sink                        bytes,
  cdc_chunk_if.source                     chunks
);

  cdc_pkg::cfg_t cfg;
  cdc_byte_if    head ();

  cdc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdc_byte_queue u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .head  (head.source)
  );

  cdc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head.sink),
    .chunks (chunks)
  );

endmodule
